@@ sv/dual_motor_limit_homing_fsm_assert.svh @@
// Assertion helpers for the checking section of the top-level RTL.
`ifndef DUAL_MOTOR_LIMIT_HOMING_FSM_ASSERT_SVH
`define DUAL_MOTOR_LIMIT_HOMING_FSM_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DMLH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define DMLH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dmlh_pkg.sv @@
package dmlh_pkg;

    localparam int PERIOD_BITS = 8;

    localparam int DUTY_W  = 8;
    localparam int TIMER_W = 14;
    localparam int REL_W   = 8;
    localparam int CMD_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
    localparam logic [DUTY_W-1:0]  ON_MAX    = {DUTY_W{1'b1}};

    localparam logic [DUTY_W-1:0]  DUTY_RESET   = 8'd30;
    localparam logic [TIMER_W-1:0] HOMING_RESET = 14'd1000;
    localparam logic [TIMER_W-1:0] SPIN_RESET   = 14'd10000;
    localparam logic [REL_W-1:0]   REL_RESET    = 8'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_DUTY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_DUTY        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOMING_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEPS  = 3'd4;

    // hand command codes
    localparam logic [CMD_W-1:0] CMD_RIGHT_UP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT_DOWN = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LEFT_UP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LEFT_DOWN  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RIGHT_STOP = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LEFT_STOP  = 3'd6;

    typedef enum logic [3:0] {
        PH_INIT     = 4'd0,
        PH_HOME     = 4'd1,
        PH_BEGIN_DN = 4'd2,
        PH_SPIN_DN  = 4'd3,
        PH_BEGIN_UP = 4'd4,
        PH_SPIN_UP  = 4'd5,
        PH_STOP     = 4'd6,
        PH_FAIL     = 4'd7,
        PH_IDLE     = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        REQ_NONE = 2'd0,
        REQ_UP   = 2'd1,
        REQ_DN   = 2'd2,
        REQ_STOP = 2'd3
    } t_req;

    typedef struct packed {
        logic [DUTY_W-1:0]  down_duty;
        logic [DUTY_W-1:0]  up_duty;
        logic [TIMER_W-1:0] homing_timeout;
        logic [TIMER_W-1:0] spin_timeout;
        logic [REL_W-1:0]   release_steps;
    } t_cfg;

    // what one machine step does to the shared duty and its own drive bits
    typedef struct packed {
        logic              duty_wr;
        logic [DUTY_W-1:0] duty;
        logic              en_set;
        logic              en_clr;
        logic              dn_wr;
        logic              dn_val;
    } t_act;

endpackage

@@ sv/dual_motor_limit_homing_fsm.sv @@
// Pipeline: an accepted transfer is held in the input register, then moves
// into the result register, from which it can transfer out.
// Throughput: one item per cycle; the input register and the result register
// keep moving as long as the result side is not stalled.
// Reset: synchronous, active low; both machines restart in init, duty 30,
// counters and drive bits cleared, configuration back to its default values.
module dual_motor_limit_homing_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dmlh_pkg::CMD_W-1:0]          i_command,
    input  logic                                i_left_limit,
    input  logic                                i_right_limit,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_left_enable,
    output logic                                o_left_down,
    output logic                                o_right_enable,
    output logic                                o_right_down,
    output logic [3:0]                          o_left_phase,
    output logic [3:0]                          o_right_phase,
    output logic [dmlh_pkg::CMD_W-1:0]          o_last_command,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dmlh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dmlh_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // ---------------- input register ----------------
    logic                         r_in_valid;
    logic [dmlh_pkg::CMD_W-1:0]   r_in_cmd;
    logic                         r_in_llim;
    logic                         r_in_rlim;
    logic                         in_accept;
    logic                         tick;      // the held item moves into the result register

    // ---------------- result register ----------------
    logic                         r_out_valid;
    logic                         r_out_len, r_out_ldn, r_out_ren, r_out_rdn;
    dmlh_pkg::t_phase             r_out_lph, r_out_rph;
    logic [dmlh_pkg::CMD_W-1:0]   r_out_cmd;

    // ---------------- shared tick state ----------------
    logic [dmlh_pkg::PERIOD_BITS-1:0] r_period;
    logic [dmlh_pkg::DUTY_W-1:0]      r_on, n_on, on_cur;
    logic [dmlh_pkg::DUTY_W-1:0]      r_duty, n_duty;
    logic                             r_len, r_ldn, r_ren, r_rdn;
    logic                             n_len, n_ldn, n_ren, n_rdn;
    logic [dmlh_pkg::CMD_W-1:0]       r_recent, n_recent;
    logic                             step, pwm_off;

    logic                 l_req_wr, r_req_wr;
    dmlh_pkg::t_req       l_req, r_req;
    dmlh_pkg::t_phase     l_phase, r_phase, l_phase_n, r_phase_n;
    dmlh_pkg::t_act       l_act, r_act;
    dmlh_pkg::t_cfg       cfg;

    // The result register frees up when it is empty or being taken this cycle.
    assign tick       = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (tick) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd  <= i_command;
            r_in_llim <= i_left_limit;
            r_in_rlim <= i_right_limit;
        end
    end

    dmlh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Decode the hand command into a per-motor request; codes zero and seven are dropped.
    always_comb begin
        l_req_wr = 1'b0;
        r_req_wr = 1'b0;
        l_req    = dmlh_pkg::REQ_NONE;
        r_req    = dmlh_pkg::REQ_NONE;
        n_recent = r_recent;
        unique case (r_in_cmd)
            dmlh_pkg::CMD_RIGHT_UP: begin
                r_req_wr = 1'b1; r_req = dmlh_pkg::REQ_UP;
            end
            dmlh_pkg::CMD_RIGHT_DOWN: begin
                r_req_wr = 1'b1; r_req = dmlh_pkg::REQ_DN;
            end
            dmlh_pkg::CMD_LEFT_UP: begin
                l_req_wr = 1'b1; l_req = dmlh_pkg::REQ_UP;
            end
            dmlh_pkg::CMD_LEFT_DOWN: begin
                l_req_wr = 1'b1; l_req = dmlh_pkg::REQ_DN;
            end
            dmlh_pkg::CMD_RIGHT_STOP: begin
                r_req_wr = 1'b1; r_req = dmlh_pkg::REQ_STOP;
            end
            dmlh_pkg::CMD_LEFT_STOP: begin
                l_req_wr = 1'b1; l_req = dmlh_pkg::REQ_STOP;
            end
            default: ;
        endcase
        if (l_req_wr || r_req_wr) n_recent = r_in_cmd;
    end

    // Machines step only on the first tick of each PWM period.
    assign step = (r_period == '0);

    dmlh_motor u_left (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick),
        .i_step       (step),
        .i_req_wr     (l_req_wr),
        .i_req        (l_req),
        .i_lim        (r_in_llim),
        .i_cfg        (cfg),
        .o_phase      (l_phase),
        .o_phase_next (l_phase_n),
        .o_act        (l_act)
    );

    dmlh_motor u_right (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick),
        .i_step       (step),
        .i_req_wr     (r_req_wr),
        .i_req        (r_req),
        .i_lim        (r_in_rlim),
        .i_cfg        (cfg),
        .o_phase      (r_phase),
        .o_phase_next (r_phase_n),
        .o_act        (r_act)
    );

    // Soft PWM: the right machine's duty write is checked first and wins. Once the
    // in-period count (before its increment) passes the duty, both enables drop.
    always_comb begin
        n_duty = r_duty;
        n_len  = r_len;
        n_ldn  = r_ldn;
        n_ren  = r_ren;
        n_rdn  = r_rdn;
        on_cur = r_on;
        if (step) begin
            if (r_act.duty_wr) n_duty = r_act.duty;
            else if (l_act.duty_wr) n_duty = l_act.duty;
            if (l_act.en_set) n_len = 1'b1;
            else if (l_act.en_clr) n_len = 1'b0;
            if (l_act.dn_wr) n_ldn = l_act.dn_val;
            if (r_act.en_set) n_ren = 1'b1;
            else if (r_act.en_clr) n_ren = 1'b0;
            if (r_act.dn_wr) n_rdn = r_act.dn_val;
            on_cur = '0;
        end
        pwm_off = on_cur > n_duty;
        if (pwm_off) begin
            n_len = 1'b0;
            n_ren = 1'b0;
        end
        // saturate the in-period count
        n_on = (on_cur != dmlh_pkg::ON_MAX) ? on_cur + 1'b1 : on_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_on     <= '0;
            r_duty   <= dmlh_pkg::DUTY_RESET;
            r_len    <= 1'b0;
            r_ldn    <= 1'b0;
            r_ren    <= 1'b0;
            r_rdn    <= 1'b0;
            r_recent <= '0;
        end else if (tick) begin
            r_period <= r_period + 1'b1;   // wraps at the period length
            r_on     <= n_on;
            r_duty   <= n_duty;
            r_len    <= n_len;
            r_ldn    <= n_ldn;
            r_ren    <= n_ren;
            r_rdn    <= n_rdn;
            r_recent <= n_recent;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_out_len <= n_len;
            r_out_ldn <= n_ldn;
            r_out_ren <= n_ren;
            r_out_rdn <= n_rdn;
            r_out_lph <= l_phase_n;
            r_out_rph <= r_phase_n;
            r_out_cmd <= n_recent;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_enable  = r_out_len;
    assign o_left_down    = r_out_ldn;
    assign o_right_enable = r_out_ren;
    assign o_right_down   = r_out_rdn;
    assign o_left_phase   = r_out_lph;
    assign o_right_phase  = r_out_rph;
    assign o_last_command = r_out_cmd;

    // ---------------- checks ----------------
`include "dual_motor_limit_homing_fsm_assert.svh"

    // failure is sticky until reset
    `DMLH_ASSERT_NEXT(a_left_fail_sticky, l_phase == dmlh_pkg::PH_FAIL,
        l_phase == dmlh_pkg::PH_FAIL, "left machine left the failed phase")
    `DMLH_ASSERT_NEXT(a_right_fail_sticky, r_phase == dmlh_pkg::PH_FAIL,
        r_phase == dmlh_pkg::PH_FAIL, "right machine left the failed phase")
    // an idle motor is never driven
    `DMLH_ASSERT_SAME(a_left_idle_off, l_phase == dmlh_pkg::PH_IDLE, !r_len,
        "left motor enabled while idle")
    `DMLH_ASSERT_SAME(a_right_idle_off, r_phase == dmlh_pkg::PH_IDLE, !r_ren,
        "right motor enabled while idle")

endmodule

@@ sv/dmlh_cfg.sv @@
module dmlh_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [dmlh_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [dmlh_pkg::CFG_DATA_W-1:0]   i_data,
    output dmlh_pkg::t_cfg                    o_cfg
);

    dmlh_pkg::t_cfg r_cfg;
    dmlh_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                dmlh_pkg::CFG_DOWN_DUTY:
                    n_cfg.down_duty = i_data[dmlh_pkg::DUTY_W-1:0];
                dmlh_pkg::CFG_UP_DUTY:
                    n_cfg.up_duty = i_data[dmlh_pkg::DUTY_W-1:0];
                dmlh_pkg::CFG_HOMING_TIMEOUT:
                    n_cfg.homing_timeout = i_data[dmlh_pkg::TIMER_W-1:0];
                dmlh_pkg::CFG_SPIN_TIMEOUT:
                    n_cfg.spin_timeout = i_data[dmlh_pkg::TIMER_W-1:0];
                dmlh_pkg::CFG_RELEASE_STEPS:
                    n_cfg.release_steps = i_data[dmlh_pkg::REL_W-1:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.down_duty      <= dmlh_pkg::DUTY_RESET;
            r_cfg.up_duty        <= dmlh_pkg::DUTY_RESET;
            r_cfg.homing_timeout <= dmlh_pkg::HOMING_RESET;
            r_cfg.spin_timeout   <= dmlh_pkg::SPIN_RESET;
            r_cfg.release_steps  <= dmlh_pkg::REL_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/dmlh_motor.sv @@
module dmlh_motor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  logic                 i_step,
    input  logic                 i_req_wr,
    input  dmlh_pkg::t_req       i_req,
    input  logic                 i_lim,
    input  dmlh_pkg::t_cfg       i_cfg,
    output dmlh_pkg::t_phase     o_phase,
    output dmlh_pkg::t_phase     o_phase_next,
    output dmlh_pkg::t_act       o_act
);

    dmlh_pkg::t_phase             r_state, n_state;
    logic [dmlh_pkg::TIMER_W-1:0] r_timer, n_timer;
    dmlh_pkg::t_req               r_pending, n_pending;
    dmlh_pkg::t_req               r_taken, n_taken;

    logic [dmlh_pkg::TIMER_W:0]   adv1, adv2;
    logic [dmlh_pkg::TIMER_W-1:0] sat1, sat2;
    logic                         spin_over, home_over, released, go_up, go_dn;

    // the request of this tick counts before the step
    assign n_pending = i_req_wr ? i_req : r_pending;

    always_comb begin
        adv1 = {1'b0, r_timer} + 1'b1;
        sat1 = adv1[dmlh_pkg::TIMER_W] ? dmlh_pkg::TIMER_MAX : adv1[dmlh_pkg::TIMER_W-1:0];
        adv2 = {1'b0, sat1} + 1'b1;
        sat2 = adv2[dmlh_pkg::TIMER_W] ? dmlh_pkg::TIMER_MAX : adv2[dmlh_pkg::TIMER_W-1:0];
        spin_over = adv1 > {1'b0, i_cfg.spin_timeout};
        home_over = adv1 > {1'b0, i_cfg.homing_timeout};
        released  = !i_lim && (adv2 > {{(dmlh_pkg::TIMER_W + 1 - dmlh_pkg::REL_W){1'b0}},
                                       i_cfg.release_steps});
        go_up = (n_pending != r_taken) && (n_pending == dmlh_pkg::REQ_UP);
        go_dn = (n_pending != r_taken) && (n_pending == dmlh_pkg::REQ_DN);
    end

    // next phase
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmlh_pkg::PH_INIT: n_state = dmlh_pkg::PH_HOME;
            dmlh_pkg::PH_HOME: begin
                if (i_lim || home_over) n_state = dmlh_pkg::PH_STOP;
            end
            dmlh_pkg::PH_BEGIN_DN, dmlh_pkg::PH_BEGIN_UP: begin
                // the release check comes first and wins over the timeout
                if (released) begin
                    n_state = (r_state == dmlh_pkg::PH_BEGIN_DN) ? dmlh_pkg::PH_SPIN_DN
                                                                 : dmlh_pkg::PH_SPIN_UP;
                end else if (spin_over) begin
                    n_state = dmlh_pkg::PH_FAIL;
                end
            end
            dmlh_pkg::PH_SPIN_DN, dmlh_pkg::PH_SPIN_UP: begin
                if (i_lim) n_state = dmlh_pkg::PH_STOP;
                else if (spin_over) n_state = dmlh_pkg::PH_FAIL;
            end
            dmlh_pkg::PH_STOP: n_state = dmlh_pkg::PH_IDLE;
            dmlh_pkg::PH_FAIL: n_state = dmlh_pkg::PH_FAIL;
            dmlh_pkg::PH_IDLE: begin
                if (go_up) n_state = dmlh_pkg::PH_BEGIN_UP;
                else if (go_dn) n_state = dmlh_pkg::PH_BEGIN_DN;
            end
            default: n_state = r_state;
        endcase
    end

    // timer, taken request and drive actions
    always_comb begin
        n_timer = r_timer;
        n_taken = r_taken;
        o_act   = '0;
        unique case (r_state)
            dmlh_pkg::PH_INIT: begin
                o_act.duty_wr = 1'b1;
                n_timer = '0;
            end
            dmlh_pkg::PH_HOME: begin
                o_act.duty_wr = 1'b1;
                o_act.duty    = i_cfg.down_duty;
                o_act.en_set  = 1'b1;
                o_act.dn_wr   = 1'b1;
                o_act.dn_val  = 1'b1;
                n_taken = dmlh_pkg::REQ_DN;
                // at the switch the descent stops without a count
                if (!i_lim) n_timer = sat1;
            end
            dmlh_pkg::PH_BEGIN_DN, dmlh_pkg::PH_BEGIN_UP,
            dmlh_pkg::PH_SPIN_DN, dmlh_pkg::PH_SPIN_UP: begin
                o_act.duty_wr = 1'b1;
                o_act.en_set  = 1'b1;
                o_act.dn_wr   = 1'b1;
                o_act.dn_val  = (r_state == dmlh_pkg::PH_BEGIN_DN) ||
                                (r_state == dmlh_pkg::PH_SPIN_DN);
                o_act.duty    = o_act.dn_val ? i_cfg.down_duty : i_cfg.up_duty;
                n_timer = ((r_state == dmlh_pkg::PH_BEGIN_DN) ||
                           (r_state == dmlh_pkg::PH_BEGIN_UP)) ? sat2 : sat1;
            end
            dmlh_pkg::PH_STOP, dmlh_pkg::PH_FAIL: begin
                o_act.duty_wr = 1'b1;
                o_act.en_clr  = 1'b1;
                n_timer = '0;
            end
            dmlh_pkg::PH_IDLE: begin
                if (go_up) begin
                    n_timer = '0;
                    n_taken = dmlh_pkg::REQ_UP;
                end else if (go_dn) begin
                    n_timer = '0;
                    n_taken = dmlh_pkg::REQ_DN;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dmlh_pkg::PH_INIT;
            r_timer   <= '0;
            r_pending <= dmlh_pkg::REQ_NONE;
            r_taken   <= dmlh_pkg::REQ_NONE;
        end else if (i_tick) begin
            r_pending <= n_pending;
            if (i_step) begin
                r_state <= n_state;
                r_timer <= n_timer;
                r_taken <= n_taken;
            end
        end
    end

    assign o_phase      = r_state;
    assign o_phase_next = i_step ? n_state : r_state;

endmodule
